FILE: hw/rtl/spfz_pkg.sv
// Shared types of the sieve prime factorizer: controller states, commands and status.
package spfz_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_SV_RD,
		ST_SV_CHK,
		ST_SV_NEXT,
		ST_MK_RD,
		ST_MK_CHK,
		ST_IDLE,
		ST_T_RD,
		ST_T_CHK,
		ST_P_RD,
		ST_P_CHK,
		ST_DSTART,
		ST_DIV,
		ST_LEFT
	} state_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLEAR,
		WR_SELF,
		WR_MARK
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_I,
		RD_J,
		RD_REM
	} rd_sel_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_ERR,
		EM_EMPTY,
		EM_FACTOR,
		EM_LEFT
	} emit_t;

	typedef struct packed {
		wr_sel_t wr_sel;
		rd_sel_t rd_sel;
		logic    clr_step;
		logic    i_init;
		logic    i_inc;
		logic    j_init;
		logic    j_step;
		logic    ld_n;
		logic    idx_init;
		logic    idx_inc;
		logic    list_rd;
		logic    p_ld_tbl;
		logic    p_ld_list;
		logic    e_clr;
		logic    div_start;
		logic    div_apply;
		emit_t   emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic i_last;
		logic tbl_zero;
		logic i_sq_le_lim;
		logic j_next_over;
		logic n_bad;
		logic n_one;
		logic n_small;
		logic idx_end;
		logic p_sq_gt_rem;
		logic div_done;
		logic div_exact;
		logic rem_one;
		logic e_nz;
	} status_t;

endpackage

FILE: hw/rtl/spfz_ram.sv
// Generic simple dual-port RAM with registered read.
module spfz_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/spfz_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
module spfz_div #(
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [31:0]   quotient,
	output logic          exact
);

	logic [5:0]    cnt_q;
	logic          run_q;
	logic          done_q;
	logic [31:0]   quo_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   sh;
	logic [DW:0]   diff;
	logic          ge;

	assign sh   = {acc_q, quo_q[31]};
	assign ge   = sh >= {1'b0, dvs_q};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			acc_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[30:0], ge};
			acc_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign exact    = (acc_q == '0);

endmodule

FILE: hw/rtl/spfz_ctrl.sv
// Controller state machine: table build sequence and factoring sequence.
module spfz_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  spfz_pkg::status_t st,
	output spfz_pkg::cmd_t   cmd,
	output logic             busy
);

	spfz_pkg::state_t state_q, state_n;
	logic mode_q, mode_n; // 1 while the trial-division path runs

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spfz_pkg::ST_CLEAR;
			mode_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			mode_q  <= mode_n;
		end
	end

	always_comb begin
		state_n = state_q;
		mode_n  = mode_q;
		cmd     = '0;
		cmd.wr_sel = spfz_pkg::WR_NONE;
		cmd.rd_sel = spfz_pkg::RD_NONE;
		cmd.emit   = spfz_pkg::EM_NONE;
		busy    = 1'b1;
		unique case (state_q)
			spfz_pkg::ST_CLEAR: begin
				cmd.wr_sel   = spfz_pkg::WR_CLEAR;
				cmd.clr_step = 1'b1;
				if (st.clr_done) begin
					cmd.i_init = 1'b1;
					state_n    = spfz_pkg::ST_SV_RD;
				end
			end
			spfz_pkg::ST_SV_RD: begin
				cmd.rd_sel = spfz_pkg::RD_I;
				state_n    = spfz_pkg::ST_SV_CHK;
			end
			spfz_pkg::ST_SV_CHK: begin
				if (st.tbl_zero) begin
					cmd.wr_sel = spfz_pkg::WR_SELF;
					cmd.j_init = 1'b1;
					state_n    = st.i_sq_le_lim ? spfz_pkg::ST_MK_RD : spfz_pkg::ST_SV_NEXT;
				end else begin
					state_n = spfz_pkg::ST_SV_NEXT;
				end
			end
			spfz_pkg::ST_SV_NEXT: begin
				if (st.i_last) begin
					state_n = spfz_pkg::ST_IDLE;
				end else begin
					cmd.i_inc = 1'b1;
					state_n   = spfz_pkg::ST_SV_RD;
				end
			end
			spfz_pkg::ST_MK_RD: begin
				cmd.rd_sel = spfz_pkg::RD_J;
				state_n    = spfz_pkg::ST_MK_CHK;
			end
			spfz_pkg::ST_MK_CHK: begin
				if (st.tbl_zero) begin
					cmd.wr_sel = spfz_pkg::WR_MARK;
				end
				cmd.j_step = 1'b1;
				state_n    = st.j_next_over ? spfz_pkg::ST_SV_NEXT : spfz_pkg::ST_MK_RD;
			end
			spfz_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.ld_n = 1'b1;
					if (st.n_bad) begin
						cmd.emit = spfz_pkg::EM_ERR;
					end else if (st.n_one) begin
						cmd.emit = spfz_pkg::EM_EMPTY;
					end else if (st.n_small) begin
						mode_n  = 1'b0;
						state_n = spfz_pkg::ST_T_RD;
					end else begin
						mode_n       = 1'b1;
						cmd.idx_init = 1'b1;
						state_n      = spfz_pkg::ST_P_RD;
					end
				end
			end
			spfz_pkg::ST_T_RD: begin
				cmd.rd_sel = spfz_pkg::RD_REM;
				state_n    = spfz_pkg::ST_T_CHK;
			end
			spfz_pkg::ST_T_CHK: begin
				cmd.p_ld_tbl = 1'b1;
				cmd.e_clr    = 1'b1;
				state_n      = spfz_pkg::ST_DSTART;
			end
			spfz_pkg::ST_P_RD: begin
				if (st.idx_end) begin
					state_n = spfz_pkg::ST_LEFT;
				end else begin
					cmd.list_rd = 1'b1;
					state_n     = spfz_pkg::ST_P_CHK;
				end
			end
			spfz_pkg::ST_P_CHK: begin
				if (st.p_sq_gt_rem) begin
					state_n = spfz_pkg::ST_LEFT;
				end else begin
					cmd.p_ld_list = 1'b1;
					cmd.e_clr     = 1'b1;
					state_n       = spfz_pkg::ST_DSTART;
				end
			end
			spfz_pkg::ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_n       = spfz_pkg::ST_DIV;
			end
			spfz_pkg::ST_DIV: begin
				if (st.div_done) begin
					if (st.div_exact) begin
						cmd.div_apply = 1'b1;
						state_n       = spfz_pkg::ST_DSTART;
					end else if (!mode_q || st.e_nz) begin
						// The prime is fully divided out; a cofactor of one ends the transaction.
						cmd.emit = spfz_pkg::EM_FACTOR;
						if (st.rem_one) begin
							state_n = spfz_pkg::ST_IDLE;
						end else if (mode_q) begin
							cmd.idx_inc = 1'b1;
							state_n     = spfz_pkg::ST_P_RD;
						end else begin
							state_n = spfz_pkg::ST_T_RD;
						end
					end else begin
						cmd.idx_inc = 1'b1;
						state_n     = spfz_pkg::ST_P_RD;
					end
				end
			end
			spfz_pkg::ST_LEFT: begin
				cmd.emit = spfz_pkg::EM_LEFT;
				state_n  = spfz_pkg::ST_IDLE;
			end
			default: begin
				state_n = spfz_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/spfz_dp.sv
// Datapath: factor table, prime list, counters, divider and result registers.
module spfz_dp #(
	parameter int SIEVE_LIMIT      = 65535,
	parameter int PRIME_LIST_DEPTH = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spfz_pkg::cmd_t    cmd,
	output spfz_pkg::status_t st,
	input  logic [31:0]       number_in,
	output logic              result_valid,
	output logic [31:0]       prime_out,
	output logic [5:0]        exponent_out,
	output logic              last_out,
	output logic              empty_out,
	output logic              error_out
);

	localparam int W  = $clog2(SIEVE_LIMIT + 1);
	localparam int IW = (PRIME_LIST_DEPTH > 1) ? $clog2(PRIME_LIST_DEPTH) : 1;
	localparam int CW = $clog2(PRIME_LIST_DEPTH + 1);
	localparam logic [63:0] TOP = 64'(SIEVE_LIMIT) * 64'(SIEVE_LIMIT);

	logic [W-1:0]  clr_q;
	logic [W-1:0]  i_q;
	logic [W:0]    j_q;
	logic [CW-1:0] pcount_q;
	logic [CW-1:0] idx_q;
	logic [W-1:0]  p_q;
	logic [31:0]   rem_q;
	logic [5:0]    e_q;

	logic          tbl_we;
	logic [W-1:0]  tbl_waddr, tbl_wdata, tbl_raddr, tbl_rdata;
	logic          tbl_re;
	logic          list_we;
	logic [W-1:0]  list_rdata;
	logic [2*W-1:0] i_sq, p_sq;
	logic [W+1:0]  j_next;
	logic          div_done, div_exact;
	logic [31:0]   div_quo;

	always_comb begin
		tbl_we    = 1'b1;
		tbl_waddr = clr_q;
		tbl_wdata = '0;
		case (cmd.wr_sel)
			spfz_pkg::WR_CLEAR: begin
				tbl_waddr = clr_q;
				tbl_wdata = '0;
			end
			spfz_pkg::WR_SELF: begin
				tbl_waddr = i_q;
				tbl_wdata = i_q;
			end
			spfz_pkg::WR_MARK: begin
				tbl_waddr = j_q[W-1:0];
				tbl_wdata = i_q;
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		tbl_re    = 1'b1;
		tbl_raddr = i_q;
		case (cmd.rd_sel)
			spfz_pkg::RD_I:   tbl_raddr = i_q;
			spfz_pkg::RD_J:   tbl_raddr = j_q[W-1:0];
			spfz_pkg::RD_REM: tbl_raddr = rem_q[W-1:0];
			default:          tbl_re    = 1'b0;
		endcase
	end

	assign list_we = (cmd.wr_sel == spfz_pkg::WR_SELF) &&
		(pcount_q != CW'(PRIME_LIST_DEPTH));

	spfz_ram #(.WIDTH(W), .DEPTH(SIEVE_LIMIT + 1), .AW(W)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	spfz_ram #(.WIDTH(W), .DEPTH(PRIME_LIST_DEPTH), .AW(IW)) u_list (
		.clk   (clk),
		.we    (list_we),
		.waddr (pcount_q[IW-1:0]),
		.wdata (i_q),
		.re    (cmd.list_rd),
		.raddr (idx_q[IW-1:0]),
		.rdata (list_rdata)
	);

	spfz_div #(.DW(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rem_q),
		.divisor  (p_q),
		.done     (div_done),
		.quotient (div_quo),
		.exact    (div_exact)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			pcount_q     <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			e_q          <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + W'(1);
			if (cmd.i_init)   i_q   <= W'(2);
			if (cmd.i_inc)    i_q   <= i_q + W'(1);
			if (cmd.j_init)   j_q   <= i_sq[W:0];
			if (cmd.j_step)   j_q   <= j_next[W:0];
			if (list_we)      pcount_q <= pcount_q + CW'(1);
			if (cmd.idx_init) idx_q <= '0;
			if (cmd.idx_inc)  idx_q <= idx_q + CW'(1);
			if (cmd.ld_n)     rem_q <= number_in;
			if (cmd.div_apply) rem_q <= div_quo;
			if (cmd.e_clr)    e_q   <= '0;
			if (cmd.div_apply) e_q  <= e_q + 6'd1;
			result_valid <= (cmd.emit != spfz_pkg::EM_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.p_ld_tbl)  p_q <= tbl_rdata;
		if (cmd.p_ld_list) p_q <= list_rdata;
		case (cmd.emit)
			spfz_pkg::EM_ERR: begin
				prime_out    <= '0;
				exponent_out <= '0;
				last_out     <= 1'b1;
				empty_out    <= 1'b0;
				error_out    <= 1'b1;
			end
			spfz_pkg::EM_EMPTY: begin
				prime_out    <= 32'd1;
				exponent_out <= '0;
				last_out     <= 1'b1;
				empty_out    <= 1'b1;
				error_out    <= 1'b0;
			end
			spfz_pkg::EM_FACTOR: begin
				prime_out    <= {{(32-W){1'b0}}, p_q};
				exponent_out <= e_q;
				last_out     <= st.rem_one;
				empty_out    <= 1'b0;
				error_out    <= 1'b0;
			end
			spfz_pkg::EM_LEFT: begin
				prime_out    <= rem_q;
				exponent_out <= 6'd1;
				last_out     <= 1'b1;
				empty_out    <= 1'b0;
				error_out    <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign i_sq   = (2*W)'(i_q) * (2*W)'(i_q);
	assign p_sq   = (2*W)'(list_rdata) * (2*W)'(list_rdata);
	assign j_next = (W+2)'(j_q) + (W+2)'(i_q);

	always_comb begin
		st.clr_done    = (clr_q == W'(SIEVE_LIMIT));
		st.i_last      = (i_q == W'(SIEVE_LIMIT));
		st.tbl_zero    = (tbl_rdata == '0);
		st.i_sq_le_lim = (i_sq <= (2*W)'(SIEVE_LIMIT));
		st.j_next_over = (j_next > (W+2)'(SIEVE_LIMIT));
		st.n_bad       = (number_in == 32'd0) || (64'(number_in) > TOP);
		st.n_one       = (number_in == 32'd1);
		st.n_small     = (number_in <= 32'(SIEVE_LIMIT));
		st.idx_end     = (idx_q == pcount_q);
		st.p_sq_gt_rem = (64'(p_sq) > 64'(rem_q));
		st.div_done    = div_done;
		st.div_exact   = div_exact;
		st.rem_one     = (rem_q == 32'd1);
		st.e_nz        = (e_q != 6'd0);
	end

endmodule

FILE: hw/rtl/sieve_prime_factorizer.sv
// Top level of the sieve prime factorizer: controller and datapath.
//
// After reset the block is busy while it clears the factor table and then
// sieves it, reading and checking each value and then each multiple of a
// prime found, marking those not yet marked. A number is taken when start
// is high and busy is low. Errors and an input of one give their single
// result in the next cycle and leave busy low. Each division starts the
// iterative divider from a start state and waits for its done flag, and a
// prime that divides with exponent e costs e+1 divisions. A number up to
// SIEVE_LIMIT takes each prime factor from the table; a larger one tries
// each stored prime up to the square root of what remains, so the divider
// sets the rate. Each result is on the outputs for exactly one cycle,
// marked by result_valid, and must be taken then: the receiver cannot
// stall the block, and busy stays high until the last result of the
// transaction has been issued.
module sieve_prime_factorizer #(
	parameter int SIEVE_LIMIT      = 65535,
	parameter int PRIME_LIST_DEPTH = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] number_in,
	output logic        busy,
	output logic        result_valid,
	output logic [31:0] prime_out,
	output logic [5:0]  exponent_out,
	output logic        last_out,
	output logic        empty_out,
	output logic        error_out
);

	spfz_pkg::cmd_t    cmd;
	spfz_pkg::status_t st;

	spfz_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	spfz_dp #(
		.SIEVE_LIMIT      (SIEVE_LIMIT),
		.PRIME_LIST_DEPTH (PRIME_LIST_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.number_in    (number_in),
		.result_valid (result_valid),
		.prime_out    (prime_out),
		.exponent_out (exponent_out),
		.last_out     (last_out),
		.empty_out    (empty_out),
		.error_out    (error_out)
	);

endmodule
